FILE: sv/ntt_pkg.sv
// ----------------------------------------------------------------------------
// NTT package
// Shared widths, modulus constants, Barrett factor and twiddle tables for the
// number theoretic transform modulo 998244353.
// ----------------------------------------------------------------------------
package ntt_pkg;

   localparam int unsigned DATA_W     = 30;
   localparam int unsigned MAX_POINTS = 64;
   localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);
   localparam int unsigned MAX_LOG    = ADDR_W;
   localparam int unsigned TW_DEPTH   = MAX_POINTS / 2;
   localparam int unsigned TW_W       = ADDR_W - 1;
   localparam int unsigned CNT_W      = ADDR_W + 1;
   localparam int unsigned LOG_W      = 3;
   localparam int unsigned PROD_W     = 2 * DATA_W;
   localparam int unsigned MU_W       = DATA_W + 1;
   localparam int unsigned RED_W      = DATA_W + 2;

   // Configuration register indexes
   localparam logic CSR_LOG_SIZE = 1'b0;
   localparam logic CSR_INVERSE  = 1'b1;

   typedef logic [DATA_W-1:0] elem_type;
   typedef elem_type tw_table_type [TW_DEPTH];

   localparam elem_type MOD_P   = 30'd998244353;
   localparam elem_type GEN     = 30'd3;
   localparam elem_type GEN_INV = 30'd332748118;

   // floor(2^60 / p) for Barrett reduction of a 60-bit product
   localparam logic [MU_W-1:0] BARRETT_MU = MU_W'((64'd1 << PROD_W) / 64'(MOD_P));

   // Elaboration-time modular product
   function automatic elem_type mul_const(input elem_type a, input elem_type b);
      logic [63:0] pr;
      pr = 64'(a) * 64'(b);
      return DATA_W'(pr % 64'(MOD_P));
   endfunction

   // Elaboration-time modular power
   function automatic elem_type pow_const(input elem_type base, input logic [31:0] expo);
      elem_type    acc;
      elem_type    bb;
      logic [31:0] e;
      acc = elem_type'(1);
      bb  = base;
      e   = expo;
      for (int k = 0; k < 32; k++) begin
         if (e[0]) begin
            acc = mul_const(acc, bb);
         end
         bb = mul_const(bb, bb);
         e  = e >> 1;
      end
      return acc;
   endfunction

   // Powers 0..TW_DEPTH-1 of the MAX_POINTS-th root of unity
   function automatic tw_table_type make_twiddles(input logic inv_dir);
      tw_table_type tbl;
      elem_type     root;
      elem_type     w;
      root = pow_const(inv_dir ? GEN_INV : GEN, 32'((MOD_P - 1) / MAX_POINTS));
      w    = elem_type'(1);
      for (int k = 0; k < TW_DEPTH; k++) begin
         tbl[k] = w;
         w      = mul_const(w, root);
      end
      return tbl;
   endfunction

   localparam tw_table_type TW_FWD = make_twiddles(1'b0);
   localparam tw_table_type TW_INV = make_twiddles(1'b1);

endpackage

FILE: sv/ntt_mulmod.sv
// ----------------------------------------------------------------------------
// NTT modular multiplier
// Four-stage pipelined a*b mod p using Barrett reduction; one result per start.
// ----------------------------------------------------------------------------
module ntt_mulmod (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  ntt_pkg::elem_type a,
   input  ntt_pkg::elem_type b,
   output logic             done,
   output ntt_pkg::elem_type result
);

   logic [3:0]                      vld_ff,  vld_in;
   logic [ntt_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [ntt_pkg::MU_W-1:0]        quo_ff,  quo_in;
   logic [ntt_pkg::RED_W-1:0]       low_ff,  low_in;
   logic [ntt_pkg::RED_W-1:0]       rem_ff,  rem_in;
   ntt_pkg::elem_type               res_ff,  res_in;
   logic [2*ntt_pkg::MU_W-1:0]      quo_full;
   logic [ntt_pkg::RED_W-1:0]       two_p;

   // Track valid stages
   assign vld_in = {vld_ff[2:0], start};

   // Stage one: full product
   assign prod_in = ntt_pkg::PROD_W'(a) * ntt_pkg::PROD_W'(b);

   // Stage two: quotient estimate
   assign quo_full = (2*ntt_pkg::MU_W)'(prod_ff[ntt_pkg::PROD_W-1:ntt_pkg::DATA_W-1])
                   * (2*ntt_pkg::MU_W)'(ntt_pkg::BARRETT_MU);
   assign quo_in   = quo_full[2*ntt_pkg::MU_W-1:ntt_pkg::MU_W];
   assign low_in   = prod_ff[ntt_pkg::RED_W-1:0];

   // Stage three: remainder below 3p
   assign rem_in = low_ff - ntt_pkg::RED_W'(ntt_pkg::PROD_W'(quo_ff)
                                           * ntt_pkg::PROD_W'(ntt_pkg::MOD_P));

   // Stage four: final correction
   assign two_p = ntt_pkg::RED_W'(ntt_pkg::MOD_P) << 1;
   always_comb begin
      if (rem_ff >= two_p) begin
         res_in = ntt_pkg::DATA_W'(rem_ff - two_p);
      end else if (rem_ff >= ntt_pkg::RED_W'(ntt_pkg::MOD_P)) begin
         res_in = ntt_pkg::DATA_W'(rem_ff - ntt_pkg::RED_W'(ntt_pkg::MOD_P));
      end else begin
         res_in = ntt_pkg::DATA_W'(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      low_ff  <= low_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign done   = vld_ff[3];
   assign result = res_ff;

endmodule

FILE: sv/ntt_mod_998244353.sv
// Sequence: the last input transfer of a frame of n points is followed by a
// bit-reverse pass, (n/2)*log2(n) butterflies (one shared modular multiplier,
// one memory write port) and an output pass that scales by 1/n when inverse.
// Frames: one at a time; loading stalls until the previous frame is streamed out.
// Reset: clears control, counters and config; the element store is not cleared.
// ----------------------------------------------------------------------------
// NTT modulo 998244353 top level
// Loads a frame into a single-port-write element store, bit-reverses it,
// runs radix-2 butterflies in place and streams the transformed vector out.
// ----------------------------------------------------------------------------
module ntt_mod_998244353 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ntt_pkg::DATA_W-1:0]        req_coefficient,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ntt_pkg::DATA_W-1:0]        rsp_value,
   output logic                              rsp_last_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [ntt_pkg::LOG_W-1:0]         csr_data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_PERM_CHK = 4'd1;
   localparam logic [3:0] S_PERM_RD  = 4'd2;
   localparam logic [3:0] S_PERM_W1  = 4'd3;
   localparam logic [3:0] S_PERM_W2  = 4'd4;
   localparam logic [3:0] S_BF_RD    = 4'd5;
   localparam logic [3:0] S_BF_MUL   = 4'd6;
   localparam logic [3:0] S_BF_WAIT  = 4'd7;
   localparam logic [3:0] S_BF_W1    = 4'd8;
   localparam logic [3:0] S_BF_W2    = 4'd9;
   localparam logic [3:0] S_OUT_RD   = 4'd10;
   localparam logic [3:0] S_OUT_MUL  = 4'd11;
   localparam logic [3:0] S_OUT_WAIT = 4'd12;
   localparam logic [3:0] S_OUT_PUT  = 4'd13;

   localparam int unsigned AW = ntt_pkg::ADDR_W;
   localparam int unsigned DW = ntt_pkg::DATA_W;
   localparam int unsigned CW = ntt_pkg::CNT_W;
   localparam int unsigned LW = ntt_pkg::LOG_W;
   localparam int unsigned TW = ntt_pkg::TW_W;

   logic [3:0]    state_ff,     state_in;
   logic [LW-1:0] log_size_ff,  log_size_in;
   logic          inverse_ff,   inverse_in;
   logic [CW-1:0] cnt_ff,       cnt_in;
   logic [LW-1:0] ls_ff,        ls_in;
   logic          inv_ff,       inv_in;
   logic [AW-1:0] idx_ff,       idx_in;
   logic [LW-1:0] stg_ff,       stg_in;
   logic [TW-1:0] bfl_ff,       bfl_in;
   logic [DW-1:0] y_ff,         y_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff,  rsp_last_in;
   logic [DW-1:0] rd_a_ff;
   logic [DW-1:0] rd_b_ff;

   logic [DW-1:0] store_mem [ntt_pkg::MAX_POINTS];

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr_a;
   logic [AW-1:0] mem_raddr_b;

   logic          mul_start;
   logic [DW-1:0] mul_a;
   logic [DW-1:0] mul_b;
   logic          mul_done;
   logic [DW-1:0] mul_res;

   logic [LW-1:0] eff_ls;
   logic          req_xfer;
   logic          rsp_xfer;
   logic [DW-1:0] coef_red;
   logic [CW-1:0] cnt_next;
   logic          frame_done;
   logic [AW-1:0] n_m1;
   logic [TW-1:0] half_m1;
   logic [AW-1:0] idx_rev;
   logic [AW-1:0] bf_ext;
   logic [TW-1:0] hmask;
   logic [AW-1:0] addr_x;
   logic [AW-1:0] addr_y;
   logic [TW-1:0] tw_idx;
   logic [DW-1:0] twiddle;
   logic [DW-1:0] n_inv;
   logic [DW:0]   bf_sum;
   logic [DW-1:0] sum_red;
   logic [DW-1:0] diff_red;
   logic          rsp_room;

   // Full bit reversal of the index, then align to the frame length
   function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v, input logic [LW-1:0] bits);
      logic [AW-1:0] r;
      r = '0;
      for (int k = 0; k < AW; k++) begin
         r[AW-1-k] = v[k];
      end
      return r >> (LW'(AW) - bits);
   endfunction

   // Shared modular multiplier
   ntt_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // Clamp the configured length
   always_comb begin
      if (log_size_ff == '0) begin
         eff_ls = LW'(1);
      end else if (log_size_ff > LW'(ntt_pkg::MAX_LOG)) begin
         eff_ls = LW'(ntt_pkg::MAX_LOG);
      end else begin
         eff_ls = log_size_ff;
      end
   end

   // Load-side helpers
   assign req_stall  = (state_ff != S_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   assign coef_red   = (req_coefficient >= ntt_pkg::MOD_P) ? (req_coefficient - ntt_pkg::MOD_P)
                                                            : req_coefficient;
   assign cnt_next   = cnt_ff + CW'(1);
   assign frame_done = ({1'b0, cnt_next} >= ((CW+1)'(1) << eff_ls));

   // Frame geometry from the latched length
   assign n_m1    = AW'((CW'(1) << ls_ff) - CW'(1));
   assign half_m1 = TW'((CW'(1) << (ls_ff - LW'(1))) - CW'(1));
   assign idx_rev = bit_rev(idx_ff, ls_ff);
   assign n_inv   = ntt_pkg::MOD_P - ((ntt_pkg::MOD_P - DW'(1)) >> ls_ff);

   // Butterfly addressing and twiddle selection
   assign hmask   = TW'((CW'(1) << stg_ff) - CW'(1));
   assign bf_ext  = {1'b0, bfl_ff};
   assign addr_x  = ((bf_ext >> stg_ff) << (stg_ff + LW'(1))) | (bf_ext & {1'b0, hmask});
   assign addr_y  = addr_x | (AW'(1) << stg_ff);
   assign tw_idx  = (bfl_ff & hmask) << (LW'(TW) - stg_ff);
   assign twiddle = inv_ff ? ntt_pkg::TW_INV[tw_idx] : ntt_pkg::TW_FWD[tw_idx];

   // Butterfly sum and difference
   assign bf_sum   = {1'b0, rd_a_ff} + {1'b0, y_ff};
   assign sum_red  = (bf_sum >= (DW+1)'(ntt_pkg::MOD_P)) ? DW'(bf_sum - (DW+1)'(ntt_pkg::MOD_P))
                                                         : DW'(bf_sum);
   assign diff_red = (rd_a_ff >= y_ff) ? (rd_a_ff - y_ff) : (rd_a_ff + ntt_pkg::MOD_P - y_ff);

   // Output register handshake
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign rsp_room = !rsp_valid_ff || !rsp_stall;

   // Configuration writes
   assign csr_ready = 1'b1;
   always_comb begin
      log_size_in = log_size_ff;
      inverse_in  = inverse_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ntt_pkg::CSR_LOG_SIZE: log_size_in = csr_data;
            ntt_pkg::CSR_INVERSE:  inverse_in  = csr_data[0];
            default:               log_size_in = log_size_ff;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ls_in        = ls_ff;
      inv_in       = inv_ff;
      idx_in       = idx_ff;
      stg_in       = stg_ff;
      bfl_in       = bfl_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = rd_a_ff;
      mem_re       = 1'b0;
      mem_raddr_a  = idx_ff;
      mem_raddr_b  = idx_rev;
      mul_start    = 1'b0;
      mul_a        = rd_b_ff;
      mul_b        = twiddle;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               mem_we    = 1'b1;
               mem_waddr = cnt_ff[AW-1:0];
               mem_wdata = coef_red;
               if (frame_done) begin
                  cnt_in   = '0;
                  ls_in    = eff_ls;
                  inv_in   = inverse_ff;
                  idx_in   = '0;
                  state_in = S_PERM_CHK;
               end else begin
                  cnt_in = cnt_next;
               end
            end
         end
         S_PERM_CHK: begin
            if (idx_ff < idx_rev) begin
               state_in = S_PERM_RD;
            end else if (idx_ff == n_m1) begin
               stg_in   = '0;
               bfl_in   = '0;
               state_in = S_BF_RD;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_PERM_RD: begin
            mem_re   = 1'b1;
            state_in = S_PERM_W1;
         end
         S_PERM_W1: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = rd_b_ff;
            state_in  = S_PERM_W2;
         end
         S_PERM_W2: begin
            mem_we    = 1'b1;
            mem_waddr = idx_rev;
            mem_wdata = rd_a_ff;
            idx_in    = idx_ff + AW'(1);
            state_in  = S_PERM_CHK;
         end
         S_BF_RD: begin
            mem_re      = 1'b1;
            mem_raddr_a = addr_x;
            mem_raddr_b = addr_y;
            state_in    = S_BF_MUL;
         end
         S_BF_MUL: begin
            mul_start = 1'b1;
            state_in  = S_BF_WAIT;
         end
         S_BF_WAIT: begin
            if (mul_done) begin
               y_in     = mul_res;
               state_in = S_BF_W1;
            end
         end
         S_BF_W1: begin
            mem_we    = 1'b1;
            mem_waddr = addr_x;
            mem_wdata = sum_red;
            state_in  = S_BF_W2;
         end
         S_BF_W2: begin
            mem_we    = 1'b1;
            mem_waddr = addr_y;
            mem_wdata = diff_red;
            if (bfl_ff == half_m1) begin
               bfl_in = '0;
               if (stg_ff == ls_ff - LW'(1)) begin
                  idx_in   = '0;
                  state_in = S_OUT_RD;
               end else begin
                  stg_in   = stg_ff + LW'(1);
                  state_in = S_BF_RD;
               end
            end else begin
               bfl_in   = bfl_ff + TW'(1);
               state_in = S_BF_RD;
            end
         end
         S_OUT_RD: begin
            mem_re   = 1'b1;
            state_in = S_OUT_MUL;
         end
         S_OUT_MUL: begin
            if (inv_ff) begin
               mul_start = 1'b1;
               mul_a     = rd_a_ff;
               mul_b     = n_inv;
               state_in  = S_OUT_WAIT;
            end else begin
               y_in     = rd_a_ff;
               state_in = S_OUT_PUT;
            end
         end
         S_OUT_WAIT: begin
            if (mul_done) begin
               y_in     = mul_res;
               state_in = S_OUT_PUT;
            end
         end
         S_OUT_PUT: begin
            if (rsp_room) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = y_ff;
               rsp_last_in  = (idx_ff == n_m1);
               if (idx_ff == n_m1) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         log_size_ff  <= LW'(ntt_pkg::MAX_LOG);
         inverse_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ls_ff        <= LW'(1);
         inv_ff       <= 1'b0;
         idx_ff       <= '0;
         stg_ff       <= '0;
         bfl_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         log_size_ff  <= log_size_in;
         inverse_ff   <= inverse_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         ls_ff        <= ls_in;
         inv_ff       <= inv_in;
         idx_ff       <= idx_in;
         stg_ff       <= stg_in;
         bfl_ff       <= bfl_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      y_ff         <= y_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Element store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_a_ff <= store_mem[mem_raddr_a];
         rd_b_ff <= store_mem[mem_raddr_b];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_last_out = rsp_last_ff;

   // Multiplier results only land while the sequencer waits for them
   a_mul_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_BF_WAIT || state_ff == S_OUT_WAIT))
      else $error("multiplier result outside a wait state");

   // Butterfly partner always lies inside the frame
   a_bf_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BF_RD) |-> (addr_y <= n_m1 && addr_x < addr_y))
      else $error("butterfly address outside frame");

   // Load count never reaches the store depth between frames
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (cnt_ff < CW'(ntt_pkg::MAX_POINTS)))
      else $error("load count out of range");

   // Final element of a frame sends the sequencer back to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT_PUT && rsp_room && idx_ff == n_m1) |=> (state_ff == S_IDLE))
      else $error("frame did not close after final element");

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// NTT modulo 998244353 testbench
// Drives frames of residues through the transform under several lengths and
// both directions, predicts every output element with a behavioural NTT and
// compares each response transfer in order. Both sides idle at random, the
// receiver holds off once for a long stretch, and the lengths are changed
// between frames and once part way through a frame.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [29:0] P     = 30'd998244353;
   localparam int RANDOM_ITEMS   = 160;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 2500;

   typedef enum logic [1:0] {
      MODE_SEND_SLOW, MODE_RECV_SLOW, MODE_FREE
   } idle_mode_type;

   typedef struct packed {
      logic        is_csr;
      logic        index;
      logic [2:0]  data;
      logic [29:0] coef;
      logic        typed;
      logic [29:0] exp0;
      logic [29:0] exp1;
   } plan_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [ntt_pkg::DATA_W-1:0]  req_coefficient;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [ntt_pkg::DATA_W-1:0]  rsp_value;
   logic                        rsp_last_out;
   logic                        csr_valid;
   logic                        csr_ready;
   logic                        csr_index;
   logic [ntt_pkg::LOG_W-1:0]   csr_data;

   // behavioural copy of the transform state
   logic [29:0] points [64];
   int          loaded;
   logic [2:0]  cur_log;
   logic        cur_inverse;

   logic [29:0]   pending_value [$];
   logic          pending_last [$];
   int            errors;
   idle_mode_type idle_mode;
   bit            hold_req;
   bit            hold_done;
   int            hold_left;
   int            quiet_cycles;
   plan_row_type  plan [$];

   ntt_mod_998244353 u_top (.*);

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic report(input string what, input logic [29:0] got, input logic [29:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic logic [29:0] mul_mod(input logic [29:0] a, input logic [29:0] b);
      logic [63:0] prod;
      prod = 64'(a) * 64'(b);
      return 30'(prod % 64'(P));
   endfunction

   function automatic logic [29:0] pow_mod(input logic [29:0] base, input logic [31:0] e);
      logic [29:0] acc;
      acc = 30'd1;
      while (e != 0) begin
         if (e[0]) acc = mul_mod(acc, base);
         base = mul_mod(base, base);
         e    = e >> 1;
      end
      return acc;
   endfunction

   // bit-reverse, butterflies, optional 1/n scale, then queue the vector
   task automatic transform_frame(input int lg, input logic typed,
                                  input logic [29:0] e0, input logic [29:0] e1);
      int          n;
      int          r;
      logic [29:0] tmp;
      logic [29:0] wn;
      logic [29:0] w;
      logic [29:0] x;
      logic [29:0] y;
      logic [29:0] scale;
      n = 1 << lg;
      for (int i = 0; i < n; i++) begin
         r = 0;
         for (int b = 0; b < lg; b++) r = (r << 1) | ((i >> b) & 1);
         if (i < r) begin
            tmp       = points[i];
            points[i] = points[r];
            points[r] = tmp;
         end
      end
      for (int h = 1; h < n; h = h << 1) begin
         wn = pow_mod(cur_inverse ? 30'd332748118 : 30'd3, (32'd998244352) / (2 * h));
         for (int j = 0; j < n; j += 2 * h) begin
            w = 30'd1;
            for (int t = 0; t < h; t++) begin
               x = points[j+t];
               y = mul_mod(w, points[j+t+h]);
               points[j+t]   = 30'((31'(x) + 31'(y)) % 31'(P));
               points[j+t+h] = (x >= y) ? x - y : 30'(31'(x) + 31'(P) - 31'(y));
               w = mul_mod(w, wn);
            end
         end
      end
      if (cur_inverse) begin
         scale = pow_mod(30'(n), 32'd998244351);
         for (int i = 0; i < n; i++) points[i] = mul_mod(points[i], scale);
      end
      for (int i = 0; i < n; i++) begin
         if (typed) pending_value.push_back(i == 0 ? e0 : e1);
         else pending_value.push_back(points[i]);
         pending_last.push_back(i == n - 1);
      end
   endtask

   // store one residue, transform when the frame is complete
   task automatic load_point(input logic [29:0] c, input logic typed,
                             input logic [29:0] e0, input logic [29:0] e1);
      int lg;
      lg = (cur_log == 0) ? 1 : (cur_log > 6 ? 6 : int'(cur_log));
      if (c >= P) c = c - P;
      points[loaded & 63] = c;
      loaded = (loaded + 1) & 127;
      if (loaded >= (1 << lg)) begin
         transform_frame(lg, typed, e0, e1);
         loaded = 0;
      end
   endtask

   function automatic bit chance(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   task automatic send_point(input logic [29:0] c, input logic typed,
                             input logic [29:0] e0, input logic [29:0] e1);
      int idle_pct;
      idle_pct = (idle_mode == MODE_SEND_SLOW) ? 35 : ((idle_mode == MODE_RECV_SLOW) ? 70 : 0);
      req_valid       <= 1'b1;
      req_coefficient <= c;
      do @(posedge clock); while (req_stall);
      load_point(c, typed, e0, e1);
      // sender gap
      if (chance(idle_pct)) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (chance(idle_pct));
      end
   endtask

   // wait for the block to drain, then write one register
   task automatic write_csr(input logic idx, input logic [2:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_value.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == ntt_pkg::CSR_LOG_SIZE) cur_log = value;
      else cur_inverse = value[0];
   endtask

   function automatic logic [29:0] random_coef();
      case ($urandom_range(9))
         0: return 30'h3FFFFFFF - 30'($urandom_range(3));
         1: return P - 30'd1 - 30'($urandom_range(1));
         2: return 30'($urandom_range(3));
         default: return 30'($urandom);
      endcase
   endfunction

   // check every response transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_value.size() == 0) begin
            report("unexpected element", rsp_value, 30'd0);
         end else begin
            if (rsp_value !== pending_value[0])
               report("value", rsp_value, pending_value[0]);
            if (rsp_last_out !== pending_last[0])
               report("last_out", 30'(rsp_last_out), 30'(pending_last[0]));
            void'(pending_value.pop_front());
            void'(pending_last.pop_front());
         end
      end
      if (hold_req && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (idle_mode)
            MODE_SEND_SLOW: rsp_stall <= chance(70);
            MODE_RECV_SLOW: rsp_stall <= chance(35);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[ntt_mod_998244353] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int lg;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_coefficient = '0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = ntt_pkg::CSR_LOG_SIZE;
      csr_data        = '0;
      errors          = 0;
      loaded          = 0;
      cur_log         = 3'd6;
      cur_inverse     = 1'b0;
      idle_mode       = MODE_SEND_SLOW;
      hold_req        = 1'b0;
      hold_done       = 1'b0;
      hold_left       = 0;
      quiet_cycles    = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed frames: two-point sums and differences, range folding,
      // inverse scaling, clamped lengths and a length change mid-frame
      plan.push_back('{1, ntt_pkg::CSR_LOG_SIZE, 3'd1, 0, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'd0, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'd0, 1, 30'd0, 30'd0});
      plan.push_back('{0, 0, 0, 30'd998244352, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'd1, 1, 30'd0, 30'd998244351});
      plan.push_back('{0, 0, 0, 30'h3FFFFFFF, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'd0, 1, 30'd75497470, 30'd75497470});
      plan.push_back('{1, ntt_pkg::CSR_INVERSE, 3'd1, 0, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'd2, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'd4, 1, 30'd3, 30'd998244352});
      plan.push_back('{1, ntt_pkg::CSR_LOG_SIZE, 3'd0, 0, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'd5, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'd5, 1, 30'd5, 30'd0});
      plan.push_back('{1, ntt_pkg::CSR_LOG_SIZE, 3'd7, 0, 0, 0, 0});
      plan.push_back('{1, ntt_pkg::CSR_INVERSE, 3'd0, 0, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'd11, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'd998244352, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'h2AAAAAAA, 0, 0, 0});
      plan.push_back('{1, ntt_pkg::CSR_LOG_SIZE, 3'd2, 0, 0, 0, 0});
      plan.push_back('{0, 0, 0, 30'h15555555, 0, 0, 0});
      plan.push_back('{1, ntt_pkg::CSR_LOG_SIZE, 3'd3, 0, 0, 0, 0});
      for (int k = 0; k < 8; k++) plan.push_back('{0, 0, 0, 30'(k * 123456789), 0, 0, 0});

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_csr(plan[i].index, plan[i].data);
         else send_point(plan[i].coef, plan[i].typed, plan[i].exp0, plan[i].exp1);
      end

      // random frames, switching idling pattern by thirds
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 3) idle_mode = MODE_RECV_SLOW;
         if (k == 2 * RANDOM_ITEMS / 3) begin
            // drain fully before the free-running part, then hold off the receiver
            req_valid <= 1'b0;
            @(posedge clock);
            wait (pending_value.size() == 0);
            idle_mode = MODE_FREE;
            hold_req  = 1'b1;
         end
         if (loaded == 0 && chance(30)) begin
            lg = chance(8) ? 6 : (chance(10) ? 0 : (chance(10) ? 7 : $urandom_range(1, 4)));
            if (lg == 5 && chance(50)) lg = 5;
            write_csr(ntt_pkg::CSR_LOG_SIZE, 3'(lg));
            write_csr(ntt_pkg::CSR_INVERSE, 3'($urandom_range(1)));
         end
         send_point(random_coef(), 1'b0, 30'd0, 30'd0);
      end
      // one mid-size frame so length five is seen
      write_csr(ntt_pkg::CSR_LOG_SIZE, 3'd5);
      for (int k = 0; k < 32; k++) send_point(random_coef(), 1'b0, 30'd0, 30'd0);
      req_valid <= 1'b0;

      wait (pending_value.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("[ntt_mod_998244353] OK");
      end else begin
         $display("[ntt_mod_998244353] ERROR");
      end
      $finish;
   end

endmodule
